// ===== src/paa_pkg.sv =====
`default_nettype none

package paa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BLOCK   = 256;
    localparam int CNT_BITS    = $clog2(MAX_BLOCK) + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_BLOCK);
    localparam int STEP_BITS   = $clog2(SUM_BITS);
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [CNT_BITS-1:0]           count_t;

    // one closed block on its way to the back end (divider or single-sample bypass)
    typedef struct packed {
        sum_t   sum;
        count_t count;
        logic   last;
    } block_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/paa_ifs.sv =====
`default_nettype none

interface paa_in_if
    import paa_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last_in_series;

    modport source (output valid, output sample, output last_in_series, input ready);
    modport sink   (input valid, input sample, input last_in_series, output ready);
endinterface

interface paa_out_if
    import paa_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t average;
    logic    series_done;

    modport source (output valid, output average, output series_done, input ready);
    modport sink   (input valid, input average, input series_done, output ready);
endinterface

`default_nettype wire

// ===== src/paa_front.sv =====
`default_nettype none

module paa_front
    import paa_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [8:0]    cfg_data,
    paa_in_if.sink             samples,
    output logic               push_valid,
    output block_t             push_data,
    input  wire logic          push_ready
);

    logic [8:0] block_size_reg;
    sum_t       sum_reg, sum_next;
    count_t     cnt_reg, cnt_next;
    count_t     eff_size;
    sum_t       sample_ext;
    sum_t       sum_inc;
    count_t     cnt_inc;
    logic       accept;
    logic       close;

    assign samples.ready = push_ready;
    assign accept        = samples.valid && push_ready;

    // zero acts as one, oversize clamps to the largest block
    always_comb
    begin
        if (block_size_reg == '0)
            eff_size = CNT_BITS'(1);
        else if ({{(CNT_BITS > 9 ? CNT_BITS - 9 : 0){1'b0}}, block_size_reg} > CNT_BITS'(MAX_BLOCK))
            eff_size = CNT_BITS'(MAX_BLOCK);
        else
            eff_size = CNT_BITS'(block_size_reg);
    end

    assign sample_ext = SUM_BITS'(samples.sample);
    assign sum_inc    = sum_reg + sample_ext;
    assign cnt_inc    = cnt_reg + CNT_BITS'(1);
    assign close      = (cnt_inc >= eff_size) || samples.last_in_series;

    assign push_valid     = samples.valid && close;
    assign push_data.sum  = sum_inc;
    assign push_data.count = cnt_inc;
    assign push_data.last = samples.last_in_series;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (close)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_inc;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= 9'd1;
            sum_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                block_size_reg <= cfg_data;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/paa_fifo.sv =====
`default_nettype none

module paa_fifo
    import paa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    input  wire block_t push_data,
    output logic        push_ready,
    output logic        pop_valid,
    output block_t      pop_data,
    input  wire logic   pop_ready
);

    block_t               mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   fill_reg, fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (fill_reg != (QPTR_BITS + 1)'(QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + QPTR_BITS'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + QPTR_BITS'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + (QPTR_BITS + 1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (QPTR_BITS + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/paa_back.sv =====
`default_nettype none

module paa_back
    import paa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pop_valid,
    input  wire block_t pop_data,
    output logic        pop_ready,
    paa_out_if.source   averages
);

    back_state_t          state_reg, state_next;
    logic [SUM_BITS-1:0]  quo_reg, quo_next;
    count_t               rem_reg, rem_next;
    count_t               div_reg, div_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 neg_reg, neg_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    sample_t              out_avg_reg, out_avg_next;
    logic                 out_done_reg, out_done_next;
    logic                 out_free;
    logic [CNT_BITS:0]    trial;
    logic [CNT_BITS:0]    trial_sub;
    logic [SUM_BITS-1:0]  sum_mag;
    sample_t              quo_low;

    assign averages.valid       = out_valid_reg;
    assign averages.average     = out_avg_reg;
    assign averages.series_done = out_done_reg;

    assign out_free = !out_valid_reg || averages.ready;

    // single-sample blocks bypass the divider
    assign pop_ready = (state_reg == ST_IDLE) &&
                       ((pop_data.count != CNT_BITS'(1)) || out_free);

    assign sum_mag   = pop_data.sum[SUM_BITS-1] ? (~pop_data.sum + SUM_BITS'(1))
                                                 : pop_data.sum;
    assign trial     = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign quo_low   = quo_reg[SAMPLE_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_done_next  = out_done_reg;

        if (out_valid_reg && averages.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    if (pop_data.count == CNT_BITS'(1))
                    begin
                        out_valid_next = 1'b1;
                        out_avg_next   = pop_data.sum[SAMPLE_BITS-1:0];
                        out_done_next  = pop_data.last;
                    end
                    else
                    begin
                        quo_next   = sum_mag;
                        rem_next   = '0;
                        div_next   = pop_data.count;
                        step_next  = '0;
                        neg_next   = pop_data.sum[SUM_BITS-1];
                        last_next  = pop_data.last;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (!trial_sub[CNT_BITS])
                begin
                    rem_next = trial_sub[CNT_BITS-1:0];
                    quo_next = {quo_reg[SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_BITS-1:0];
                    quo_next = {quo_reg[SUM_BITS-2:0], 1'b0};
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = neg_reg ? (~quo_low + SAMPLE_BITS'(1)) : quo_low;
                    out_done_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        neg_reg     <= neg_next;
        last_reg    <= last_next;
        out_avg_reg <= out_avg_next;
        out_done_reg <= out_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/piecewise_aggregate_average.sv =====
// path: a closing sample writes its block into the queue; a one-sample block is then popped
//   straight into the output register, larger blocks pass the bit-serial divider and ST_OUT first
// throughput: one sample per cycle while the queue has room; averages of one-sample blocks
//   leave at one per cycle while the output is taken; other blocks hold the back end, which pops
//   no new block until the divided average is loaded; a 4-entry queue absorbs bursts
// reset: asynchronous, active low; clears sum, count, queue and output valid; block size reads 1
`default_nettype none

module piecewise_aggregate_average
    import paa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_data,
    paa_in_if.sink          samples,
    paa_out_if.source       averages
);

    logic   push_valid;
    logic   push_ready;
    block_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    block_t pop_data;

    paa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .samples    (samples),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    paa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    paa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .averages  (averages)
    );

endmodule

`default_nettype wire

// ===== src/paa_checker.sv =====
`default_nettype none

module paa_checker
    import paa_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire sample_t out_average,
    input wire logic    out_series_done
);

    // nothing is pending while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("word pending during reset");

    // input is ready (queue not full) on the first cycle out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("stalled word dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_average) && $stable(out_series_done))
        else $error("stalled word changed");

endmodule

bind piecewise_aggregate_average paa_checker u_paa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (samples.ready),
    .out_valid       (averages.valid),
    .out_ready       (averages.ready),
    .out_average     (averages.average),
    .out_series_done (averages.series_done)
);

`default_nettype wire

// ===== tb/sv/paa_average_checker.sv =====
`timescale 1ns / 100ps

module paa_average_checker
    import paa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_data,
    paa_in_if               samples,
    paa_out_if              averages,
    output int              errors,
    output int              pending
);

    typedef struct packed {
        sample_t average;
        logic    series_done;
    } avg_word_t;

    logic [8:0] block_len;
    sum_t       open_sum;
    count_t     open_count;
    avg_word_t  expected_avgs[$];

    function automatic void absorb_sample(input sample_t s, input logic last);
        count_t    limit;
        longint    mean;
        avg_word_t w;
        // zero acts as one, anything above the largest block acts as the largest
        if (block_len == 9'd0)
            limit = count_t'(1);
        else if (block_len > count_t'(MAX_BLOCK))
            limit = count_t'(MAX_BLOCK);
        else
            limit = block_len;
        open_sum   = open_sum + sum_t'(s);
        open_count = open_count + count_t'(1);
        if (open_count < limit && !last)
            return;
        // signed division truncates toward zero
        mean = longint'(open_sum) / longint'(open_count);
        w.average     = sample_t'(mean);
        w.series_done = last;
        expected_avgs = {expected_avgs, w};
        open_sum   = '0;
        open_count = '0;
    endfunction

    always @(posedge clk)
    begin
        avg_word_t want;
        if (!rst_n)
        begin
            block_len  = 9'd1;
            open_sum   = '0;
            open_count = '0;
            expected_avgs.delete();
            errors = 0;
        end
        else
        begin
            if (averages.valid && averages.ready)
            begin
                if (expected_avgs.size() == 0)
                begin
                    $error("average word with none expected: average %0d, series_done %0b",
                           averages.average, averages.series_done);
                    errors++;
                end
                else
                begin
                    want = expected_avgs.pop_front();
                    if (averages.average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d", want.average,
                               averages.average);
                        errors++;
                    end
                    if (averages.series_done !== want.series_done)
                    begin
                        $error("series_done: expected %0b, got %0b", want.series_done,
                               averages.series_done);
                        errors++;
                    end
                end
            end
            if (samples.valid && samples.ready)
                absorb_sample(samples.sample, samples.last_in_series);
            if (cfg_we)
                block_len = cfg_data;
        end
        pending = expected_avgs.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import paa_pkg::*;

    localparam int SETTLE      = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int NPHASE      = 12;

    localparam logic [8:0] PHASE_BLOCK [NPHASE] = '{
        9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd16, 9'd255, 9'd511, 9'd300, 9'd4, 9'd7
    };
    localparam int PHASE_WORDS [NPHASE] = '{
        90, 40, 60, 60, 60, 60, 60, 40, 40, 40, 60, 40
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_data;
    int         errors;
    int         pending;
    int         results_seen;
    int         burst_left;

    paa_in_if  samples_ch();
    paa_out_if averages_ch();

    piecewise_aggregate_average dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samples_ch),
        .averages (averages_ch)
    );

    paa_average_checker averages_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samples_ch),
        .averages (averages_ch),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sample_t pick_sample(input int style);
        case (style)
            1: return sample_t'($urandom_range(16384, 32767));
            2: return sample_t'(-int'($urandom_range(16384, 32768)));
            default:
                case ($urandom_range(0, 7))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
                    default: return sample_t'($urandom);
                endcase
        endcase
    endfunction

    // one word per call, sent in bursts with random gaps between them
    task automatic offer(input sample_t s, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                samples_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        samples_ch.valid          <= 1'b1;
        samples_ch.sample         <= s;
        samples_ch.last_in_series <= last;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_block(input logic [8:0] size);
        samples_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= size;
        @(negedge clk);
        cfg_we     <= 1'b0;
        burst_left = 0;
    endtask

    initial
    begin
        int style;
        int series_span;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 9'd0;
        samples_ch.valid = 1'b0;
        samples_ch.sample = '0;
        samples_ch.last_in_series = 1'b0;
        burst_left = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // block size out of reset
        offer(16'sh7FFF, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(sample_t'(0), 1'b1);
        offer(sample_t'(-1), 1'b0);
        offer(sample_t'(1), 1'b1);

        // pairs: extremes, truncation toward zero, short final block
        set_block(9'd2);
        offer(16'sh8000, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh7FFF, 1'b0);
        offer(16'sh7FFF, 1'b1);
        offer(sample_t'(-1), 1'b0);
        offer(sample_t'(0), 1'b0);
        offer(sample_t'(-3), 1'b0);
        offer(sample_t'(0), 1'b0);
        offer(sample_t'(5), 1'b1);

        set_block(9'd0);
        offer(sample_t'(-7), 1'b1);
        offer(sample_t'(7), 1'b0);

        // size lowered while a block is open
        set_block(9'd3);
        offer(sample_t'(100), 1'b0);
        offer(sample_t'(200), 1'b0);
        set_block(9'd1);
        offer(sample_t'(300), 1'b0);

        // full-size blocks at both ends of the sample range
        set_block(9'd256);
        repeat (MAX_BLOCK) offer(16'sh8000, 1'b0);
        set_block(9'd300);
        repeat (MAX_BLOCK) offer(16'sh7FFF, 1'b0);

        for (int p = 0; p < NPHASE; p++)
        begin
            set_block(PHASE_BLOCK[p]);
            style       = $urandom_range(0, 3);
            series_span = $urandom_range(2, 80);
            repeat (PHASE_WORDS[p])
                offer(pick_sample(style), $urandom_range(1, series_span) == 1);
        end

        samples_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // output side stalls on its own pattern, with one long hold-off
    initial
    begin
        int  mode;
        int  span;
        int  stall_left;
        bit  hold_done;
        averages_ch.ready = 1'b0;
        mode = 0;
        span = 0;
        stall_left = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 20)
            begin
                hold_done = 1'b1;
                averages_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    0: averages_ch.ready <= 1'b1;
                    1: averages_ch.ready <= 1'($urandom_range(0, 1));
                    2: averages_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            averages_ch.ready <= 1'b0;
                            stall_left--;
                        end
                        else
                        begin
                            averages_ch.ready <= 1'b1;
                            if ($urandom_range(0, 7) == 0)
                                stall_left = $urandom_range(4, 16);
                        end
                    end
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (averages_ch.valid && averages_ch.ready)
                results_seen++;
            if ((samples_ch.valid && samples_ch.ready) ||
                (averages_ch.valid && averages_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
